// ===== src/gmds_pkg.sv =====
// Shared types, codes and constants of the grid maze depth-first solver.
`timescale 1ns / 1ps

package gmds_pkg;

	// Default grid capacity.
	localparam int DEF_MAX_COLS = 64;
	localparam int DEF_MAX_ROWS = 64;

	// Configuration port.
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 7;

	localparam logic [CFG_AW-1:0] REG_MAZE_WIDTH  = 3'd0;
	localparam logic [CFG_AW-1:0] REG_MAZE_HEIGHT = 3'd1;
	localparam logic [CFG_AW-1:0] REG_START_COL   = 3'd2;
	localparam logic [CFG_AW-1:0] REG_START_ROW   = 3'd3;
	localparam logic [CFG_AW-1:0] REG_GOAL_COL    = 3'd4;
	localparam logic [CFG_AW-1:0] REG_GOAL_ROW    = 3'd5;

	localparam logic [6:0] RST_MAZE_WIDTH  = 7'd64;
	localparam logic [6:0] RST_MAZE_HEIGHT = 7'd64;
	localparam logic [5:0] RST_START_COL   = 6'd0;
	localparam logic [5:0] RST_START_ROW   = 6'd0;
	localparam logic [5:0] RST_GOAL_COL    = 6'd63;
	localparam logic [5:0] RST_GOAL_ROW    = 6'd63;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_SOLVE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_ACK     = 2'd0,
		STAT_SOLVED  = 2'd1,
		STAT_NO_PATH = 2'd2,
		STAT_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		DIR_LEFT  = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_UP    = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	typedef struct packed {
		logic [6:0] maze_width;
		logic [6:0] maze_height;
		logic [5:0] start_col;
		logic [5:0] start_row;
		logic [5:0] goal_col;
		logic [5:0] goal_row;
	} cfg_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] cell_col;
		logic [5:0] cell_row;
		logic [3:0] wall_bits;
		logic [11:0] step_index;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [11:0] path_length;
		dir_t        step_direction;
	} res_t;

endpackage

// ===== src/grid_maze_dfs_solver_top.sv =====
// Top level of the grid maze depth-first solver: stream ports, registers, output stage.
`timescale 1ns / 1ps

// The block takes command words on the s_axis channel and returns exactly one result
// word per command on the m_axis channel. s_axis_tuser carries the opcode: write the
// walls of one cell, solve, or read one step of the current path. Registers (maze size,
// start and goal cell) are written through cfg_we/cfg_addr/cfg_wdata, and the user
// must write them only while the block is idle; the block does not enforce this. They
// take effect on the next command. Commands are handled one at a time. A wall write,
// an undefined opcode or a path read goes through the done state after acceptance; a
// path read first waits in read-wait, as the path memory has a registered read port.
// A solve with an in-range start first sweeps the visited memory, one entry per cycle
// (MAX_COLS * MAX_ROWS entries, 4096 by default), then walks: a forward move goes
// through the walk, probe and check states, with one more probe and check for each
// visited neighbour tried first; a step back goes through walk, probe and pop after
// the same probes. The visited memory, read once per neighbour, sets the walk rate.
// Reset clears the registers to a 64 by 64 maze from the top-left to the bottom-right
// cell, clears the path length, and empties the output register. Wall contents are
// undefined until written. When the receiver stalls, the result stays in the output
// register; the sequencer may take and finish one more command, which then waits.

module grid_maze_dfs_solver_top #(
	parameter int MAX_COLS = gmds_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = gmds_pkg::DEF_MAX_ROWS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration write port.
	input  logic                         cfg_we,
	input  logic [gmds_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [gmds_pkg::CFG_DW-1:0]  cfg_wdata,
	// Command channel.
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// tdata fields from bit 0: cell_col[5:0], cell_row[11:6], wall_bits[15:12],
	// step_index[27:16], zero fill [31:28].
	input  logic [31:0]                  s_axis_tdata,
	// tuser fields from bit 0: op[1:0].
	input  logic [1:0]                   s_axis_tuser,
	// Result channel.
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// tdata fields from bit 0: path_length[11:0], step_direction[13:12], zero fill [15:14].
	output logic [15:0]                  m_axis_tdata,
	// tuser fields from bit 0: status[1:0].
	output logic [1:0]                   m_axis_tuser
);

	gmds_pkg::cfg_t  cfg_q;
	gmds_pkg::cmd_t  cmd;
	gmds_pkg::res_t  res;
	gmds_pkg::res_t  out_q;
	logic            out_valid_q;
	logic            res_valid;
	logic            res_ready;

	// Register file. Writes to indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.maze_width  <= gmds_pkg::RST_MAZE_WIDTH;
			cfg_q.maze_height <= gmds_pkg::RST_MAZE_HEIGHT;
			cfg_q.start_col   <= gmds_pkg::RST_START_COL;
			cfg_q.start_row   <= gmds_pkg::RST_START_ROW;
			cfg_q.goal_col    <= gmds_pkg::RST_GOAL_COL;
			cfg_q.goal_row    <= gmds_pkg::RST_GOAL_ROW;
		end else if (cfg_we) begin
			case (cfg_addr)
				gmds_pkg::REG_MAZE_WIDTH:  cfg_q.maze_width  <= cfg_wdata;
				gmds_pkg::REG_MAZE_HEIGHT: cfg_q.maze_height <= cfg_wdata;
				gmds_pkg::REG_START_COL:   cfg_q.start_col   <= cfg_wdata[5:0];
				gmds_pkg::REG_START_ROW:   cfg_q.start_row   <= cfg_wdata[5:0];
				gmds_pkg::REG_GOAL_COL:    cfg_q.goal_col    <= cfg_wdata[5:0];
				gmds_pkg::REG_GOAL_ROW:    cfg_q.goal_row    <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	// Unpack the command word.
	always_comb begin
		cmd.op         = gmds_pkg::op_t'(s_axis_tuser);
		cmd.cell_col   = s_axis_tdata[5:0];
		cmd.cell_row   = s_axis_tdata[11:6];
		cmd.wall_bits  = s_axis_tdata[15:12];
		cmd.step_index = s_axis_tdata[27:16];
	end

	gmds_core #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (s_axis_tvalid),
		.cmd_ready (s_axis_tready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: the core hands over its result whenever the slot is empty or is
	// being emptied in the same cycle.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q.step_direction, out_q.path_length};
	assign m_axis_tuser  = out_q.status;

endmodule

// ===== src/gmds_ram.sv =====
// Simple dual-port synchronous RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module gmds_ram #(
	parameter int DW    = 1,
	parameter int DEPTH = 2,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/gmds_core.sv =====
// Command sequencer and depth-first walk over the wall, visited and path memories.
`timescale 1ns / 1ps

module gmds_core #(
	parameter int MAX_COLS = gmds_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = gmds_pkg::DEF_MAX_ROWS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gmds_pkg::cfg_t  cfg,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  gmds_pkg::cmd_t  cmd,
	output logic            res_valid,
	input  logic            res_ready,
	output gmds_pkg::res_t  res
);

	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int NW    = $clog2(CELLS + 1);
	localparam int CW    = (MAX_COLS > 64) ? $clog2(MAX_COLS) : 6;
	localparam int RW    = (MAX_ROWS > 64) ? $clog2(MAX_ROWS) : 6;
	localparam int CW1   = CW + 1;
	localparam int RW1   = RW + 1;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_CLEAR  = 8'b0000_0010,
		ST_WALK   = 8'b0000_0100,
		ST_PROBE  = 8'b0000_1000,
		ST_CHECK  = 8'b0001_0000,
		ST_POP    = 8'b0010_0000,
		ST_RDWAIT = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	state_t           state_q;
	logic [NW-1:0]    n_q;
	logic [NW-1:0]    pc_q;
	logic [AW-1:0]    clr_q;
	logic [CW-1:0]    cc_q;
	logic [RW-1:0]    cr_q;
	logic [AW-1:0]    idx_q;
	logic [2:0]       d_q;
	logic             hit_q;
	gmds_pkg::res_t   res_q;

	logic [CW:0]      w_c;
	logic [RW:0]      h_c;
	logic             empty_c;
	logic             start_in_c;
	logic             at_goal_c;
	logic             wr_in_c;
	logic [AW-1:0]    idx_c;
	logic [3:0]       open_c;
	logic [3:0]       cand_c;
	logic             has_cand_c;
	gmds_pkg::dir_t   sel_c;
	logic [AW-1:0]    nb_addr_c;
	logic             mv_en_c;
	gmds_pkg::dir_t   mv_dir_c;

	logic             wall_we, wall_re;
	logic [AW-1:0]    wall_wa;
	logic [3:0]       wall_rd;
	logic             vis_we, vis_re, vis_wd;
	logic [AW-1:0]    vis_wa;
	logic [0:0]       vis_rd;
	logic             stk_we, stk_re;
	logic [AW-1:0]    stk_ra;
	logic [1:0]       stk_rd;

	// Used area of the grid, clamped to the capacity.
	assign w_c = (32'(cfg.maze_width) > MAX_COLS) ? CW1'(MAX_COLS) : CW1'(cfg.maze_width);
	assign h_c = (32'(cfg.maze_height) > MAX_ROWS) ? RW1'(MAX_ROWS) : RW1'(cfg.maze_height);
	assign empty_c    = (w_c == '0) || (h_c == '0);
	assign start_in_c = (CW1'(cfg.start_col) < w_c) && (RW1'(cfg.start_row) < h_c);
	assign at_goal_c  = (cc_q == CW'(cfg.goal_col)) && (cr_q == RW'(cfg.goal_row));
	assign wr_in_c    = (32'(cmd.cell_col) < MAX_COLS) && (32'(cmd.cell_row) < MAX_ROWS);
	assign wall_wa    = AW'(32'(cmd.cell_row) * MAX_COLS + 32'(cmd.cell_col));
	assign idx_c      = AW'(32'(cr_q) * MAX_COLS + 32'(cc_q));

	// Open neighbours of the current cell, then those at or after the next direction to try.
	always_comb begin
		open_c[0] = (cc_q != '0) && !wall_rd[0];
		open_c[1] = ((CW1'(cc_q) + CW1'(1)) < w_c) && !wall_rd[1];
		open_c[2] = (cr_q != '0) && !wall_rd[2];
		open_c[3] = ((RW1'(cr_q) + RW1'(1)) < h_c) && !wall_rd[3];
		cand_c     = open_c & 4'(4'b1111 << d_q);
		has_cand_c = |cand_c;
		if (cand_c[0]) begin
			sel_c = gmds_pkg::DIR_LEFT;
		end else if (cand_c[1]) begin
			sel_c = gmds_pkg::DIR_RIGHT;
		end else if (cand_c[2]) begin
			sel_c = gmds_pkg::DIR_UP;
		end else begin
			sel_c = gmds_pkg::DIR_DOWN;
		end
		case (sel_c)
			gmds_pkg::DIR_LEFT:  nb_addr_c = idx_q - AW'(1);
			gmds_pkg::DIR_RIGHT: nb_addr_c = idx_q + AW'(1);
			gmds_pkg::DIR_UP:    nb_addr_c = idx_q - AW'(MAX_COLS);
			default:             nb_addr_c = idx_q + AW'(MAX_COLS);
		endcase
	end

	// Cursor moves forward after a fresh neighbour, or back along the popped move.
	always_comb begin
		mv_en_c  = ((state_q == ST_CHECK) && !vis_rd[0]) || (state_q == ST_POP);
		mv_dir_c = (state_q == ST_POP) ? gmds_pkg::dir_t'(stk_rd ^ 2'b01)
		                               : gmds_pkg::dir_t'(d_q[1:0]);
	end

	// Memory port control. Each state touches at most one entry of each memory, and a
	// written entry is never the one read in the same or the following cycle.
	always_comb begin
		wall_we = 1'b0;
		wall_re = 1'b0;
		vis_we  = 1'b0;
		vis_re  = 1'b0;
		vis_wa  = idx_c;
		vis_wd  = 1'b0;
		stk_we  = 1'b0;
		stk_re  = 1'b0;
		stk_ra  = AW'(cmd.step_index);
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					wall_we = (cmd.op == gmds_pkg::OP_WRITE) && wr_in_c;
					stk_re  = (cmd.op == gmds_pkg::OP_READ);
				end
			end
			ST_CLEAR: begin
				vis_we = 1'b1;
				vis_wa = clr_q;
			end
			ST_WALK: begin
				if (!at_goal_c) begin
					vis_we  = 1'b1;
					vis_wd  = 1'b1;
					wall_re = 1'b1;
				end
			end
			ST_PROBE: begin
				if (has_cand_c) begin
					vis_re = 1'b1;
				end else if (n_q != '0) begin
					stk_re = 1'b1;
					stk_ra = AW'(n_q - NW'(1));
				end
			end
			ST_CHECK: begin
				stk_we = !vis_rd[0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			pc_q    <= '0;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							gmds_pkg::OP_SOLVE: begin
								if (empty_c) begin
									state_q <= ST_DONE;
								end else if (!start_in_c) begin
									pc_q    <= '0;
									state_q <= ST_DONE;
								end else begin
									clr_q   <= '0;
									state_q <= ST_CLEAR;
								end
							end
							gmds_pkg::OP_READ: state_q <= ST_RDWAIT;
							default:           state_q <= ST_DONE;
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1)) begin
						n_q     <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (at_goal_c) begin
						pc_q    <= n_q;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (has_cand_c) begin
						state_q <= ST_CHECK;
					end else if (n_q == '0) begin
						pc_q    <= '0;
						state_q <= ST_DONE;
					end else begin
						n_q     <= n_q - NW'(1);
						state_q <= ST_POP;
					end
				end
				ST_CHECK: begin
					if (!vis_rd[0]) begin
						n_q     <= n_q + NW'(1);
						state_q <= ST_WALK;
					end else begin
						state_q <= ST_PROBE;
					end
				end
				ST_POP:    state_q <= ST_WALK;
				ST_RDWAIT: state_q <= ST_DONE;
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					res_q.status         <= gmds_pkg::STAT_ACK;
					res_q.path_length    <= 12'(pc_q);
					res_q.step_direction <= gmds_pkg::DIR_LEFT;
					hit_q                <= 32'(cmd.step_index) < 32'(pc_q);
					if (cmd.op == gmds_pkg::OP_SOLVE) begin
						if (empty_c) begin
							res_q.status <= gmds_pkg::STAT_EMPTY;
						end else if (!start_in_c) begin
							res_q.status      <= gmds_pkg::STAT_NO_PATH;
							res_q.path_length <= '0;
						end
					end
				end
			end
			ST_CLEAR: begin
				cc_q <= CW'(cfg.start_col);
				cr_q <= RW'(cfg.start_row);
			end
			ST_WALK: begin
				idx_q <= idx_c;
				d_q   <= '0;
				if (at_goal_c) begin
					res_q.status      <= gmds_pkg::STAT_SOLVED;
					res_q.path_length <= 12'(n_q);
				end
			end
			ST_PROBE: begin
				if (has_cand_c) begin
					d_q <= {1'b0, sel_c};
				end else if (n_q == '0) begin
					res_q.status      <= gmds_pkg::STAT_NO_PATH;
					res_q.path_length <= '0;
				end
			end
			ST_CHECK: begin
				if (vis_rd[0]) begin
					d_q <= d_q + 3'd1;
				end
			end
			ST_RDWAIT: begin
				if (hit_q) begin
					res_q.step_direction <= gmds_pkg::dir_t'(stk_rd);
				end
			end
			default: ;
		endcase
		if (mv_en_c) begin
			case (mv_dir_c)
				gmds_pkg::DIR_LEFT:  cc_q <= cc_q - CW'(1);
				gmds_pkg::DIR_RIGHT: cc_q <= cc_q + CW'(1);
				gmds_pkg::DIR_UP:    cr_q <= cr_q - RW'(1);
				default:             cr_q <= cr_q + RW'(1);
			endcase
		end
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	gmds_ram #(.DW(4), .DEPTH(CELLS), .AW(AW)) u_wall_ram (
		.clk   (clk),
		.we    (wall_we),
		.waddr (wall_wa),
		.wdata (cmd.wall_bits),
		.re    (wall_re),
		.raddr (idx_c),
		.rdata (wall_rd)
	);

	gmds_ram #(.DW(1), .DEPTH(CELLS), .AW(AW)) u_visit_ram (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_wa),
		.wdata (vis_wd),
		.re    (vis_re),
		.raddr (nb_addr_c),
		.rdata (vis_rd)
	);

	gmds_ram #(.DW(2), .DEPTH(CELLS), .AW(AW)) u_path_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (AW'(n_q)),
		.wdata (d_q[1:0]),
		.re    (stk_re),
		.raddr (stk_ra),
		.rdata (stk_rd)
	);

	// Path cells are distinct, so the stack never reaches the cell count.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(CELLS - 1))
		else $error("path stack depth beyond cell count");

	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) && !vis_rd[0] |=> (n_q == $past(n_q) + NW'(1)))
		else $error("forward move did not push the path stack");

	a_wall_ack: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd.op == gmds_pkg::OP_WRITE)
		|=> res_valid && (res.status == gmds_pkg::STAT_ACK))
		else $error("wall write not acknowledged in the next cycle");

	a_nopath_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == gmds_pkg::STAT_NO_PATH) |-> (res.path_length == '0))
		else $error("no-path result carries a nonzero length");

endmodule
